[rtl/sof_pkg.sv]
// Shared constants, types and helper functions of the spectral onset function block.
package sof_pkg;

	// Store geometry.
	localparam int MAX_BINS = 1025;
	localparam int CHANNELS = 1;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int CNT_W    = $clog2(MAX_BINS + 1);
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * MAX_BINS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CLR_W    = $clog2(DEPTH + 1);

	// Field widths.
	localparam int MAG_W      = 16;
	localparam int ACC_W      = 48;
	localparam int CHAN_OUT_W = 3;
	localparam int MODE_W     = 2;
	localparam int NB_W       = 11;
	localparam int TERM_W     = (2 * MAG_W > CNT_W + MAG_W) ? 2 * MAG_W : CNT_W + MAG_W;

	// Configuration port.
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MODE     = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_BINS = 1'b1;

	// Mode codes.
	localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HFC    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUX   = 2'd2;

	// Register reset values.
	localparam logic [MODE_W-1:0] MODE_RST     = MODE_HFC;
	localparam logic [NB_W-1:0]   NUM_BINS_RST = 11'd513;

	localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};

	// Register contents seen by the datapath.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [NB_W-1:0]   num_bins;
	} cfg_t;

	// One read and one write request to the magnitude store.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [MAG_W-1:0]  wr_data;
	} store_req_t;

	// One per-bin term on its way to the accumulator.
	typedef struct packed {
		logic              last;
		logic [CH_W-1:0]   ch;
		logic [TERM_W-1:0] term;
	} term_word_t;

	// Bins per frame, clamped to 1..MAX_BINS.
	function automatic logic [CNT_W-1:0] sof_eff_bins(input logic [NB_W-1:0] num_bins);
		logic [31:0] nb;
		nb = 32'(num_bins);
		if (nb == 32'd0) begin
			return CNT_W'(1);
		end
		if (nb > 32'(MAX_BINS)) begin
			return CNT_W'(MAX_BINS);
		end
		return CNT_W'(nb);
	endfunction

endpackage

[rtl/spectral_onset_function.sv]
// Top level of the spectral onset function: bin counting, store access and term computation.
//
// Takes one 16-bit Q8.8 magnitude word per cycle, channel-major and bin-minor,
// and counts bin and channel itself. After the last bin of a channel frame it
// delivers one word holding the saturated 48-bit onset value (energy, high
// frequency content or spectral flux, chosen by the mode register) with the
// channel index on tuser. Sustained rate is one input word per clock; the
// per-bin work is a read of the previous-frame magnitude store, a multiply or
// subtract and a write-back, with a forwarding path for a bin that is read at
// the same edge that writes it back. The last bin's term passes the stage one,
// term and output word registers. Input words keep flowing while an output word
// waits; only a second frame end behind an untaken output word stalls the input.
// After reset the store is cleared one entry per cycle, so no input word is
// accepted until all 1025 entries (the store depth, channels times maximum bins)
// are cleared; register writes are taken throughout.
module spectral_onset_function
	import sof_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [MAG_W-1:0]      s_tdata,   // [15:0] magnitude
	// Output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ACC_W-1:0]      m_tdata,   // [47:0] onset_value
	output logic [CHAN_OUT_W-1:0] m_tuser,   // [2:0] channel
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	cfg_t              cfg;
	store_req_t        store_req;
	logic [MAG_W-1:0]  store_rd_data;
	logic              store_ready;

	logic [BIN_W-1:0]  bin_q;
	logic [CH_W-1:0]   ch_q;
	logic [BIN_W-1:0]  bin_cur;
	logic [CH_W-1:0]   ch_cur;
	logic [CNT_W-1:0]  eff_bins;
	logic [CNT_W-1:0]  bin_next;
	logic              last_cur;
	logic [ADDR_W-1:0] addr_cur;
	logic              accept;

	logic              valid_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [MODE_W-1:0] mode_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              fwd_s1;
	logic [MAG_W-1:0]  fwd_data_s1;
	logic [MAG_W-1:0]  prev_mag;
	logic [CNT_W-1:0]  weight;
	term_word_t        term_word;
	logic              adv1;
	logic              adv2;

	sof_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sof_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (store_rd_data),
		.ready   (store_ready)
	);

	sof_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_word  (term_word),
		.in_ready (adv2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Handshake: the first stage moves whenever the term stage can take its word.
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1 && store_ready;
	assign accept   = s_tvalid && s_tready;

	// Current bin and channel, frame end detection and store address.
	always_comb begin
		bin_cur  = (32'(bin_q) >= 32'(MAX_BINS)) ? BIN_W'(MAX_BINS - 1) : bin_q;
		ch_cur   = (32'(ch_q) >= 32'(CHANNELS)) ? '0 : ch_q;
		eff_bins = sof_eff_bins(cfg.num_bins);
		bin_next = CNT_W'(bin_cur) + CNT_W'(1);
		last_cur = (bin_next >= eff_bins);
		addr_cur = ADDR_W'(32'(ch_cur) * MAX_BINS + 32'(bin_cur));
	end

	// Bin and channel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			ch_q  <= '0;
		end else if (accept) begin
			if (last_cur) begin
				bin_q <= '0;
				ch_q  <= (32'(ch_cur) + 32'd1 >= 32'(CHANNELS)) ? '0 : ch_cur + CH_W'(1);
			end else begin
				bin_q <= bin_next[BIN_W-1:0];
				ch_q  <= ch_cur;
			end
		end
	end

	// Store access, in flux mode only: read at acceptance, write back when the word leaves stage one.
	always_comb begin
		store_req.rd_en   = accept && (cfg.mode == MODE_FLUX);
		store_req.rd_addr = addr_cur;
		store_req.wr_en   = valid_s1 && adv2 && (mode_s1 == MODE_FLUX);
		store_req.wr_addr = addr_s1;
		store_req.wr_data = mag_s1;
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept;
		end
	end

	// A word written back at the edge that reads the same entry is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1      <= s_tdata;
			bin_s1      <= bin_cur;
			ch_s1       <= ch_cur;
			mode_s1     <= cfg.mode;
			last_s1     <= last_cur;
			addr_s1     <= addr_cur;
			fwd_s1      <= valid_s1 && (mode_s1 == MODE_FLUX) && (addr_s1 == addr_cur);
			fwd_data_s1 <= mag_s1;
		end
	end

	// Per-bin term of the selected mode.
	always_comb begin
		prev_mag         = fwd_s1 ? fwd_data_s1 : store_rd_data;
		weight           = CNT_W'(bin_s1) + CNT_W'(1);
		term_word.last   = last_s1;
		term_word.ch     = ch_s1;
		case (mode_s1)
			MODE_ENERGY: term_word.term = TERM_W'(mag_s1) * TERM_W'(mag_s1);
			MODE_HFC:    term_word.term = TERM_W'(weight) * TERM_W'(mag_s1);
			MODE_FLUX:   term_word.term = (mag_s1 > prev_mag) ?
			                              TERM_W'(mag_s1 - prev_mag) : '0;
			default:     term_word.term = '0;
		endcase
	end

	// The bin counter never leaves the store range.
	a_bin_in_range: assert property (
		@(posedge clk) disable iff (!arst_n)
		32'(bin_q) < 32'(MAX_BINS)
	) else $error("bin counter out of range");

	// A stalled first stage keeps its word.
	a_s1_holds: assert property (
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> (valid_s1 && $stable(mag_s1) && $stable(addr_s1))
	) else $error("stage one word changed while stalled");

	// No input word is taken before the store has been cleared.
	a_accept_after_clear: assert property (
		@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> store_ready
	) else $error("input word accepted during clearing pass");

endmodule

[rtl/sof_cfg.sv]
// Configuration registers behind the APB-style port.
module sof_cfg
	import sof_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [MODE_W-1:0]    mode_q;
	logic [NB_W-1:0]      num_bins_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RST;
			num_bins_q <= NUM_BINS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:     mode_q     <= pwdata[MODE_W-1:0];
				REG_NUM_BINS: num_bins_q <= pwdata[NB_W-1:0];
				default:      ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			REG_MODE:     prdata = PDATA_W'(mode_q);
			REG_NUM_BINS: prdata = PDATA_W'(num_bins_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.mode     = mode_q;
	assign cfg.num_bins = num_bins_q;

endmodule

[rtl/sof_store.sv]
// Previous-frame magnitude store with its clearing pass after reset.
module sof_store
	import sof_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  store_req_t       req,
	output logic [MAG_W-1:0] rd_data,
	output logic             ready
);

	logic [MAG_W-1:0] mem_q [DEPTH];
	logic [MAG_W-1:0] rd_data_q;
	logic [CLR_W-1:0] clr_cnt_q;
	logic             clearing;

	assign clearing = (clr_cnt_q != CLR_W'(DEPTH));
	assign ready    = !clearing;
	assign rd_data  = rd_data_q;

	// Clearing pass, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	// Single write port and registered read port; a read at the written address
	// returns the old word.
	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_q[clr_cnt_q[ADDR_W-1:0]] <= '0;
		end else if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// No access may be issued before the clearing pass is over.
	a_no_access_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.rd_en && !req.wr_en
	) else $error("store accessed during clearing pass");

endmodule

[rtl/sof_accum.sv]
// Term register, saturating frame accumulator and output word register.
module sof_accum
	import sof_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  term_word_t            in_word,
	output logic                  in_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ACC_W-1:0]      m_tdata,
	output logic [CHAN_OUT_W-1:0] m_tuser
);

	logic                  valid_s2;
	term_word_t            word_s2;
	logic [ACC_W-1:0]      acc_q;
	logic                  out_valid_q;
	logic [ACC_W-1:0]      out_data_q;
	logic [CHAN_OUT_W-1:0] out_ch_q;
	logic                  take_s2;
	logic [ACC_W:0]        sum;
	logic [ACC_W-1:0]      sum_sat;

	// The term stage drains unless it closes a frame while the output word waits.
	assign take_s2  = valid_s2 && (!word_s2.last || !out_valid_q || m_tready);
	assign in_ready = !valid_s2 || take_s2;

	// Saturating addition of the term to the running sum.
	assign sum     = {1'b0, acc_q} + (ACC_W + 1)'(word_s2.term);
	assign sum_sat = sum[ACC_W] ? ACC_SAT : sum[ACC_W-1:0];

	// Term stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s2 <= in_word;
		end
	end

	// Accumulator and output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s2 && word_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (take_s2) begin
				acc_q <= word_s2.last ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && word_s2.last) begin
			out_data_q <= sum_sat;
			out_ch_q   <= CHAN_OUT_W'(word_s2.ch);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ch_q;

	// A frame end is held back only by an output word that is not taken.
	a_stall_only_on_full_output: assert property (
		@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !in_ready) |-> (m_tvalid && !m_tready && word_s2.last)
	) else $error("term stage stalled without a blocked output word");

endmodule
